>>> design/dstq_pkg.sv
// Shared constants, codes and types for the deadline-sorted task queue.
package dstq_pkg;

    localparam int TASKS        = 8;
    localparam int IDX_W        = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int ID_W         = IDX_W;
    localparam int POS_W        = IDX_W + 2;
    localparam int SEARCH_STEPS = $clog2(TASKS + 1);

    localparam int OP_W    = 3;
    localparam int TASK_W  = 3;
    localparam int TICK_W  = 24;
    localparam int EPOCH_W = 8;
    localparam int DL_W    = 32;
    localparam int CNT_W   = 4;
    localparam int SUM_W   = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;

    localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_DELAY  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND    = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME     = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD_PERIOD = 3'd4;
    localparam logic [OP_W-1:0] OP_POLL       = 3'd5;

    localparam logic [DL_W-1:0] DL_ALL_ONES = 32'hffff_ffff;
    localparam logic [DL_W-1:0] TICK_MASK   = 32'h00ff_ffff;
    localparam logic [7:0]      WRAP_MARK   = 8'h01;

    localparam logic [CNT_W-1:0] CNT_MAX   = 4'd15;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'((TASKS > 15) ? 15 : TASKS);

    // per-cell update select
    typedef logic [2:0] cell_sel_t;
    localparam cell_sel_t SEL_HOLD  = 3'd0;
    localparam cell_sel_t SEL_PREV  = 3'd1;
    localparam cell_sel_t SEL_NEXT  = 3'd2;
    localparam cell_sel_t SEL_LOAD  = 3'd3;
    localparam cell_sel_t SEL_CLEAR = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } slot_t;

    typedef struct packed {
        logic place;
        logic from_head;
        logic clear;
    } search_req_t;

endpackage

>>> design/dstq_cell.sv
// One list position: task number plus its deadline, with neighbor shift.
module dstq_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dstq_pkg::ID_W-1:0]      slot_id,
    input  dstq_pkg::cell_sel_t            sel,
    input  dstq_pkg::slot_t                load,
    input  dstq_pkg::slot_t                prev,
    input  dstq_pkg::slot_t                nxt,
    input  logic [dstq_pkg::DL_W-1:0]      key,
    input  logic [dstq_pkg::TASK_W-1:0]    task_num,
    output dstq_pkg::slot_t                slot,
    output logic                           key_below,
    output logic                           hit,
    output logic                           mark
);
    import dstq_pkg::*;

    localparam int CMP_W = (ID_W > TASK_W) ? ID_W : TASK_W;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        unique case (sel)
            SEL_HOLD:  slot_next = slot_reg;
            SEL_PREV:  slot_next = prev;
            SEL_NEXT:  slot_next = nxt;
            SEL_LOAD:  slot_next = load;
            SEL_CLEAR: slot_next = '{id: slot_reg.id, dl: slot_reg.dl & TICK_MASK};
            default:   slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg.id <= slot_id;
            slot_reg.dl <= DL_ALL_ONES;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot      = slot_reg;
    assign key_below = key < slot_reg.dl;
    assign hit       = (CMP_W'(slot_reg.id) == CMP_W'(task_num));
    assign mark      = (slot_reg.dl[DL_W-1:TICK_W] == WRAP_MARK);

endmodule

>>> design/dstq_search.sv
// Upper-bound search over the cell compares and per-cell shift selects.
module dstq_search (
    input  dstq_pkg::search_req_t                     req,
    input  logic [dstq_pkg::TASKS-1:0]                below,
    input  logic [dstq_pkg::TASKS-1:0]                hit,
    input  logic [dstq_pkg::TASKS-1:0]                mark,
    output dstq_pkg::cell_sel_t [dstq_pkg::TASKS-1:0] sel
);
    import dstq_pkg::*;

    localparam logic signed [POS_W-1:0] POS_ONE = 1;

    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] mid;
    logic signed [POS_W-1:0] u;
    logic signed [POS_W-1:0] p;
    logic signed [POS_W-1:0] pos;

    // binary search on the compare bits, same probe order as a software search
    always_comb
    begin
        lo  = req.from_head ? POS_ONE : '0;
        hi  = POS_W'(TASKS - 1);
        mid = '0;
        for (int k = 0; k < SEARCH_STEPS; k++)
        begin
            if (lo <= hi)
            begin
                mid = (lo + hi) >>> 1;
                if (below[mid[IDX_W-1:0]])
                    hi = mid - POS_ONE;
                else
                    lo = mid + POS_ONE;
            end
        end
        u = hi + POS_ONE;
    end

    // current position of the task; the head for a period update
    always_comb
    begin
        p = '0;
        if (!req.from_head)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                if (hit[i])
                    p = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            pos    = POS_W'(i);
            sel[i] = SEL_HOLD;
            if (req.place)
            begin
                if (u > p)
                begin
                    if (pos >= p && pos < u - POS_ONE)
                        sel[i] = SEL_NEXT;
                    else if (pos == u - POS_ONE)
                        sel[i] = SEL_LOAD;
                end
                else if (u < p)
                begin
                    if (pos > u && pos <= p)
                        sel[i] = SEL_PREV;
                    else if (pos == u)
                        sel[i] = SEL_LOAD;
                end
                else if (pos == p)
                begin
                    sel[i] = SEL_LOAD;
                end
            end
            else if (req.clear && mark[i])
            begin
                sel[i] = SEL_CLEAR;
            end
        end
    end

endmodule

>>> design/deadline_sorted_task_queue_unit.sv
// Top level: request register, cell row, counters and poll result register.
// Each request is registered in its transfer cycle with its new deadline (one
// add); from the request register it then updates the whole cell row at once.
// A poll result goes through the request register, then the result register.
// A new request is taken only once the last has executed; a poll waits on an unread result.
// Reset (async, active low): cell i holds task i with an all-ones deadline,
// wait count is TASKS saturated to 15, saved epoch is zero, output empty.
module deadline_sorted_task_queue_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dstq_pkg::OP_W-1:0]      opcode,
    input  logic [dstq_pkg::TASK_W-1:0]    task_req,
    input  logic [dstq_pkg::TICK_W-1:0]    delay,
    input  logic [dstq_pkg::TICK_W-1:0]    now_tick,
    input  logic [dstq_pkg::EPOCH_W-1:0]   epoch,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           due,
    output logic [dstq_pkg::TASK_W-1:0]    head_task
);
    import dstq_pkg::*;

    logic                   busy_reg,        busy_next;
    logic                   out_valid_reg,   out_valid_next;
    logic [CNT_W-1:0]       wait_cnt_reg,    wait_cnt_next;
    logic [EPOCH_W-1:0]     saved_epoch_reg, saved_epoch_next;
    logic [OP_W-1:0]        op_reg;
    logic [TASK_W-1:0]      task_reg;
    logic [DL_W-1:0]        key_reg,         key_next;
    logic [TICK_W-1:0]      now_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic                   due_reg,         due_next;
    logic [TASK_W-1:0]      head_reg;

    slot_t                  slots     [TASKS];
    slot_t                  prev_slot [TASKS];
    slot_t                  next_slot [TASKS];
    slot_t                  load_slot;
    logic [TASKS-1:0]       below;
    logic [TASKS-1:0]       hit;
    logic [TASKS-1:0]       mark;
    cell_sel_t [TASKS-1:0]  sel;
    search_req_t            req;

    logic                   accept;
    logic                   stall;
    logic                   fire;
    logic                   task_ok;
    logic                   is_move;
    logic                   is_period;
    logic                   is_poll;
    logic                   ep_diff;
    logic                   clear_ok;
    logic [DL_W-1:0]        old_dl;
    logic [DL_W-1:0]        head_dl;
    logic [DL_W-1:0]        poll_t;
    logic [SUM_W-1:0]       mark_cnt;

    function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
        cnt_up = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] c);
        cnt_down = (c == '0) ? c : c - CNT_W'(1);
    endfunction

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    // new deadline, formed while the row is quiet
    always_comb
    begin
        unique case (opcode)
            OP_CREATE,
            OP_ADD_DELAY:  key_next = DL_W'(25'(now_tick) + 25'(delay));
            OP_SUSPEND:    key_next = DL_ALL_ONES;
            OP_RESUME:     key_next = DL_W'(now_tick);
            OP_ADD_PERIOD: key_next = slots[0].dl + DL_W'(delay);
            default:       key_next = DL_W'(now_tick);
        endcase
    end

    assign is_poll   = (op_reg == OP_POLL);
    assign stall     = is_poll && out_valid_reg && !out_ready;
    assign fire      = busy_reg && !stall;
    assign task_ok   = (32'(task_reg) < TASKS);
    assign is_move   = task_ok && (op_reg == OP_CREATE || op_reg == OP_ADD_DELAY
                                   || op_reg == OP_SUSPEND || op_reg == OP_RESUME);
    assign is_period = (op_reg == OP_ADD_PERIOD);

    assign ep_diff  = (epoch_reg != saved_epoch_reg);
    assign clear_ok = is_poll && ep_diff && (32'(wait_cnt_reg) >= TASKS);

    assign req.place     = fire && (is_move || is_period);
    assign req.from_head = is_period;
    assign req.clear     = fire && clear_ok;

    assign load_slot.id = is_period ? slots[0].id : ID_W'(task_reg);
    assign load_slot.dl = key_reg;

    always_comb
    begin
        old_dl = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            if (hit[i])
                old_dl = old_dl | slots[i].dl;
        end
    end

    assign mark_cnt = SUM_W'($countones(mark));
    assign head_dl  = (clear_ok && mark[0]) ? (slots[0].dl & TICK_MASK) : slots[0].dl;
    // epoch moved on but marks cannot be cleared yet: treat now as end of range
    assign poll_t   = (ep_diff && !clear_ok) ? TICK_MASK : DL_W'(now_reg);
    assign due_next = (poll_t >= head_dl);

    always_comb
    begin
        wait_cnt_next = wait_cnt_reg;
        if (fire)
        begin
            if (op_reg == OP_CREATE && task_ok)
            begin
                if (key_reg[DL_W-1:TICK_W] != '0)
                    wait_cnt_next = cnt_up(wait_cnt_reg);
                else
                    wait_cnt_next = cnt_down(wait_cnt_reg);
            end
            else if (op_reg == OP_ADD_DELAY && task_ok)
            begin
                if (old_dl[DL_W-1:TICK_W] == '0 && key_reg[DL_W-1:TICK_W] == WRAP_MARK)
                    wait_cnt_next = cnt_up(wait_cnt_reg);
            end
            else if (is_period)
            begin
                if (key_reg[DL_W-1:TICK_W] == WRAP_MARK)
                    wait_cnt_next = cnt_up(wait_cnt_reg);
            end
            else if (clear_ok)
            begin
                if (mark_cnt >= SUM_W'(wait_cnt_reg))
                    wait_cnt_next = '0;
                else
                    wait_cnt_next = CNT_W'(SUM_W'(wait_cnt_reg) - mark_cnt);
            end
        end
    end

    assign saved_epoch_next = (fire && clear_ok) ? epoch_reg : saved_epoch_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (fire)
            busy_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && is_poll)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            wait_cnt_reg    <= CNT_RESET;
            saved_epoch_reg <= '0;
        end
        else
        begin
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
            wait_cnt_reg    <= wait_cnt_next;
            saved_epoch_reg <= saved_epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            task_reg  <= task_req;
            key_reg   <= key_next;
            now_reg   <= now_tick;
            epoch_reg <= epoch;
        end
        if (fire && is_poll)
        begin
            due_reg  <= due_next;
            head_reg <= TASK_W'(slots[0].id);
        end
    end

    genvar g;
    generate
        for (g = 0; g < TASKS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign prev_slot[g] = slots[g];
            end
            else
            begin : g_mid_prev
                assign prev_slot[g] = slots[g-1];
            end
            if (g == TASKS - 1)
            begin : g_last
                assign next_slot[g] = slots[g];
            end
            else
            begin : g_mid_next
                assign next_slot[g] = slots[g+1];
            end

            dstq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .slot_id   (ID_W'(g)),
                .sel       (sel[g]),
                .load      (load_slot),
                .prev      (prev_slot[g]),
                .nxt       (next_slot[g]),
                .key       (key_reg),
                .task_num  (task_reg),
                .slot      (slots[g]),
                .key_below (below[g]),
                .hit       (hit[g]),
                .mark      (mark[g])
            );
        end
    endgenerate

    dstq_search u_search (
        .req   (req),
        .below (below),
        .hit   (hit),
        .mark  (mark),
        .sel   (sel)
    );

    assign out_valid = out_valid_reg;
    assign due       = due_reg;
    assign head_task = head_reg;

endmodule

>>> design/dstq_checker.sv
// Port-level checks for the task queue, bound to the top level.
module dstq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [dstq_pkg::OP_W-1:0]      opcode,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           due,
    input logic [dstq_pkg::TASK_W-1:0]    head_task
);
    import dstq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(due) && $stable(head_task))
        else $error("poll result changed while stalled");

    // one request in the row at a time
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new transfer taken while a request is executing");

    // a fresh result comes only from an earlier poll transfer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && opcode == OP_POLL, 2))
        else $error("result without a matching poll");

    // other requests never produce a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode != OP_POLL && !out_valid |=> ##1 !out_valid)
        else $error("result produced by a non-poll request");

endmodule

bind deadline_sorted_task_queue_unit dstq_checker u_dstq_checker (.*);

>>> test/tb.sv
// Testbench for the deadline-sorted task queue: random and directed requests against a scoreboard.
`timescale 1ns / 1ps

module tb;
    import dstq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 1850;
    localparam int CALM_TAIL      = 300;

    typedef struct packed {
        logic              due;
        logic [TASK_W-1:0] head;
    } poll_result_t;

    // Shadow copy of the queue state and the poll results it predicts.
    class deadline_scoreboard;
        logic [DL_W-1:0]    dl [TASKS];
        logic [TASK_W-1:0]  ord [TASKS];
        logic [CNT_W-1:0]   wait_cnt;
        logic [EPOCH_W-1:0] last_epoch;
        poll_result_t       polls_pending [$];
        int                 errors;
        int                 polls_seen;

        function new();
            for (int i = 0; i < TASKS; i++)
            begin
                dl[i]  = DL_ALL_ONES;
                ord[i] = TASK_W'(i);
            end
            wait_cnt   = CNT_RESET;
            last_epoch = '0;
            errors     = 0;
            polls_seen = 0;
        endfunction

        function void count_up();
            if (wait_cnt < CNT_MAX)
                wait_cnt++;
        endfunction

        function void count_down();
            if (wait_cnt > 0)
                wait_cnt--;
        endfunction

        // binary search, kept exact: the list need not be sorted after a wrap clear
        function int upper_bound(int first, logic [DL_W-1:0] v);
            int lo;
            int hi;
            int mid;
            lo = first;
            hi = TASKS - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (v < dl[ord[mid]])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return hi + 1;
        endfunction

        function void place(int tid, logic [DL_W-1:0] v);
            int p;
            int u;
            p = -1;
            for (int i = 0; i < TASKS; i++)
            begin
                if (ord[i] == tid)
                begin
                    p = i;
                    break;
                end
            end
            if (p < 0)
                return;
            u = upper_bound(0, v);
            if (u > p)
            begin
                for (int i = p; i < u - 1; i++)
                    ord[i] = ord[i + 1];
                ord[u - 1] = TASK_W'(tid);
            end
            else if (u < p)
            begin
                for (int i = p; i > u; i--)
                    ord[i] = ord[i - 1];
                ord[u] = TASK_W'(tid);
            end
            dl[tid] = v;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                   logic [TICK_W-1:0] dly, logic [TICK_W-1:0] now,
                                   logic [EPOCH_W-1:0] ep);
            logic [7:0]        top_before;
            logic [DL_W-1:0]   t;
            logic [TASK_W-1:0] h;
            int                u;
            poll_result_t      res;
            if (op <= OP_RESUME && int'(tid) >= TASKS)
                return;
            case (op)
                OP_CREATE:
                begin
                    place(int'(tid), {8'h00, now} + {8'h00, dly});
                    if (dl[tid][31:24] != 8'h00)
                        count_up();
                    else
                        count_down();
                end
                OP_ADD_DELAY:
                begin
                    top_before = dl[tid][31:24];
                    place(int'(tid), {8'h00, now} + {8'h00, dly});
                    if (dl[tid][31:24] == WRAP_MARK && top_before == 8'h00)
                        count_up();
                end
                OP_SUSPEND:
                    place(int'(tid), DL_ALL_ONES);
                OP_RESUME:
                    place(int'(tid), {8'h00, now});
                OP_ADD_PERIOD:
                begin
                    h = ord[0];
                    dl[h] = dl[h] + {8'h00, dly};
                    u = upper_bound(1, dl[h]);
                    for (int i = 1; i < u; i++)
                        ord[i - 1] = ord[i];
                    ord[u - 1] = h;
                    if (dl[h][31:24] == WRAP_MARK)
                        count_up();
                end
                OP_POLL:
                begin
                    t = {8'h00, now};
                    if (ep != last_epoch)
                    begin
                        t = TICK_MASK;
                        if (int'(wait_cnt) >= TASKS)
                        begin
                            for (int i = 0; i < TASKS; i++)
                            begin
                                if (dl[i][31:24] == WRAP_MARK)
                                begin
                                    dl[i] = dl[i] & TICK_MASK;
                                    count_down();
                                end
                            end
                            last_epoch = ep;
                            t = {8'h00, now};
                        end
                    end
                    res.due  = (t >= dl[ord[0]]);
                    res.head = ord[0];
                    polls_pending.push_back(res);
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic d, logic [TASK_W-1:0] h);
            poll_result_t want;
            polls_seen++;
            if (polls_pending.size() == 0)
            begin
                report($sformatf("poll result %0d (due=%0d head=%0d) with none pending",
                                 polls_seen, d, h));
                return;
            end
            want = polls_pending.pop_front();
            if (d !== want.due)
                report($sformatf("poll result %0d: due=%0d, want %0d", polls_seen, d, want.due));
            if (h !== want.head)
                report($sformatf("poll result %0d: head_task=%0d, want %0d",
                                 polls_seen, h, want.head));
        endtask

        function int pending();
            return polls_pending.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [TASK_W-1:0]   task_req;
    logic [TICK_W-1:0]   delay;
    logic [TICK_W-1:0]   now_tick;
    logic [EPOCH_W-1:0]  epoch;
    logic                out_valid;
    logic                out_ready;
    logic                due;
    logic [TASK_W-1:0]   head_task;

    deadline_scoreboard  sb;
    int                  items_sent = 0;
    bit                  idle_on = 1'b1;
    int                  send_idle_pct = 25;
    int                  recv_stall_pct = 25;
    logic [TICK_W-1:0]   sim_now = '0;
    logic [EPOCH_W-1:0]  sim_epoch = '0;

    deadline_sorted_task_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .task_req  (task_req),
        .delay     (delay),
        .now_tick  (now_tick),
        .epoch     (epoch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .due       (due),
        .head_task (head_task)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                logic [TICK_W-1:0] dly, logic [TICK_W-1:0] now,
                                logic [EPOCH_W-1:0] ep);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        task_req <= tid;
        delay    <= dly;
        now_tick <= now;
        epoch    <= ep;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op, tid, dly, now, ep);
        items_sent++;
        // idle density changes every hundred transfers, including stretches of none
        if (items_sent % 100 == 0)
        begin
            send_idle_pct  = 25 * $urandom_range(0, 2);
            recv_stall_pct = 25 * $urandom_range(0, 2);
        end
        if (idle_on && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // creates and delay adds past the wrap push the wait count up, then the epoch turns over
    task automatic wrap_burst();
        int n;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] dly;
        n = $urandom_range(6, 12);
        repeat (n)
        begin
            now = TICK_W'($urandom_range(24'hf00000, 24'hffffff));
            dly = TICK_W'($urandom_range(24'h100000, 24'hffffff));
            if ($urandom_range(0, 3) == 0)
                send_request(OP_ADD_DELAY, TASK_W'($urandom), dly, now, sim_epoch);
            else
                send_request(OP_CREATE, TASK_W'($urandom), dly, now, sim_epoch);
        end
        sim_epoch++;
        sim_now = TICK_W'($urandom_range(0, 4095));
        send_request(OP_POLL, TASK_W'($urandom), TICK_W'($urandom), sim_now, sim_epoch);
    endtask

    task automatic send_random_item();
        int r;
        int pick;
        logic [OP_W-1:0]   op;
        logic [TICK_W-1:0] dly;
        logic [TICK_W-1:0] step;
        logic [TICK_W:0]   sum;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            send_request(OP_W'($urandom), TASK_W'($urandom), TICK_W'($urandom),
                         TICK_W'($urandom), EPOCH_W'($urandom));
            return;
        end
        if (r < 17)
        begin
            wrap_burst();
            return;
        end
        if ($urandom_range(0, 9) == 0)
            step = TICK_W'($urandom);
        else
            step = TICK_W'($urandom_range(0, 2047));
        sum = {1'b0, sim_now} + {1'b0, step};
        if (sum[TICK_W])
            sim_epoch++;
        sim_now = sum[TICK_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_POLL;
        else if (pick < 55)
            op = OP_CREATE;
        else if (pick < 65)
            op = OP_ADD_DELAY;
        else if (pick < 70)
            op = OP_SUSPEND;
        else if (pick < 80)
            op = OP_RESUME;
        else if (pick < 95)
            op = OP_ADD_PERIOD;
        else if (pick < 98)
            op = OP_SPARE_A;
        else
            op = OP_SPARE_B;
        case ($urandom_range(0, 5))
            0:       dly = '0;
            1:       dly = '1;
            2, 3:    dly = TICK_W'($urandom_range(0, 8191));
            default: dly = TICK_W'($urandom);
        endcase
        send_request(op, TASK_W'($urandom), dly, sim_now, sim_epoch);
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = '0;
        task_req = '0;
        delay    = '0;
        now_tick = '0;
        epoch    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // poll right after reset, then an epoch change with a full wait count
        send_request(OP_POLL, 3'd0, 24'h000000, 24'h000000, 8'h00);
        send_request(OP_POLL, 3'd7, 24'hffffff, 24'hffffff, 8'h01);
        send_request(OP_CREATE, 3'd3, 24'h000000, 24'h000000, 8'h01);
        send_request(OP_CREATE, 3'd5, 24'hffffff, 24'hffffff, 8'h01);
        send_request(OP_ADD_DELAY, 3'd3, 24'hffffff, 24'h000010, 8'h01);
        // equal deadlines go after the ones already listed
        send_request(OP_RESUME, 3'd2, 24'h000000, 24'h123456, 8'h01);
        send_request(OP_RESUME, 3'd6, 24'h000000, 24'h123456, 8'h01);
        send_request(OP_RESUME, 3'd1, 24'h000000, 24'h123456, 8'h01);
        send_request(OP_POLL, 3'd0, 24'h000000, 24'h123456, 8'h01);
        send_request(OP_ADD_PERIOD, 3'd0, 24'hffffff, 24'h000000, 8'h01);
        send_request(OP_ADD_PERIOD, 3'd0, 24'h000000, 24'h000000, 8'h01);
        send_request(OP_SUSPEND, 3'd2, 24'h000000, 24'h000000, 8'h01);
        send_request(OP_SUSPEND, 3'd0, 24'h000000, 24'h000000, 8'h01);
        send_request(OP_CREATE, 3'd0, 24'hffffff, 24'hff0000, 8'h01);
        send_request(OP_CREATE, 3'd4, 24'h800000, 24'h900000, 8'h01);
        send_request(OP_POLL, 3'd0, 24'h000000, 24'h000100, 8'h02);
        send_request(OP_POLL, 3'd0, 24'h000000, 24'h000000, 8'h02);
        send_request(OP_SPARE_A, 3'd1, 24'h00abcd, 24'h000200, 8'h02);
        send_request(OP_SPARE_B, 3'd6, 24'hffffff, 24'hffffff, 8'hff);
        repeat (4) send_request(OP_CREATE, 3'd7, 24'h000001, 24'h000005, 8'h02);
        // epoch change while the wait count is low: time reads as all ones
        send_request(OP_POLL, 3'd0, 24'h000000, 24'h000005, 8'h03);
        send_request(OP_POLL, 3'd0, 24'h000000, 24'hffffff, 8'h02);
        sim_now   = 24'h000005;
        sim_epoch = 8'h02;

        while (items_sent < TOTAL_ITEMS)
        begin
            idle_on = (items_sent < TOTAL_ITEMS - CALM_TAIL);
            send_random_item();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[deadline_sorted_task_queue_unit] OK");
        else
            $display("[deadline_sorted_task_queue_unit] ERROR");
        $finish;
    end

    initial
    begin : receiver
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 99) < recv_stall_pct)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 3);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(due, head_task);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[deadline_sorted_task_queue_unit] ERROR");
        $finish;
    end

endmodule
